@@ rtl/irc_mft_pkg.sv @@
// Shared types and codes for the IRC message field tagger.
package irc_mft_pkg;

    // Largest number of parameters that one message may carry.
    localparam int MAX_PARAMS = 15;
    localparam int PARAMS_W   = 5;

    // Token kinds from the lexer.
    localparam logic [2:0] TOK_COLON = 3'd0;
    localparam logic [2:0] TOK_SPACE = 3'd1;
    localparam logic [2:0] TOK_EOL   = 3'd2;
    localparam logic [2:0] TOK_DIGIT = 3'd3;
    localparam logic [2:0] TOK_ALPHA = 3'd4;
    localparam logic [2:0] TOK_OTHER = 3'd5;
    localparam logic [2:0] TOK_EOI   = 3'd6;
    localparam logic [2:0] TOK_SPARE = 3'd7;

    // Roles given to each token.
    localparam logic [2:0] ROLE_PREFIX  = 3'd0;
    localparam logic [2:0] ROLE_COMMAND = 3'd1;
    localparam logic [2:0] ROLE_PARAM   = 3'd2;
    localparam logic [2:0] ROLE_DELIM   = 3'd3;
    localparam logic [2:0] ROLE_END     = 3'd4;
    localparam logic [2:0] ROLE_IGNORED = 3'd5;

    // Error codes.
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_BAD_CMD  = 3'd1;
    localparam logic [2:0] ERR_CODE_LEN = 3'd2;
    localparam logic [2:0] ERR_TOO_MANY = 3'd3;
    localparam logic [2:0] ERR_NO_CMD   = 3'd4;

    localparam logic [3:0] DIGIT_MAX    = 4'd9;
    localparam logic [2:0] CODE_DIGITS  = 3'd3;
    localparam logic [2:0] CMD_LEN_MAX  = 3'd7;

    typedef struct packed {
        logic [2:0] token_kind;
        logic [3:0] digit_value;
    } token_t;

    typedef struct packed {
        logic [2:0] role;
        logic [3:0] param_index;
        logic       command_is_numeric;
        logic [9:0] command_code;
        logic [3:0] param_total;
        logic [2:0] error_code;
        logic       last;
    } result_t;

endpackage

@@ rtl/irc_message_field_tagger_core.sv @@
// Top level of the IRC message field tagger: token register, tagging logic, result register.
//
//   Channel  Direction  Handshake                   Payload
//   token    in         token_valid / token_stall   token  (token_t)
//   result   out        result_valid / result_stall result (result_t)
//
// One token is accepted per cycle while token_stall is low; each gives exactly one result beat, held first in
// the input register and then in the result register. The per-message state (phase, command, parameter count)
// is updated as the token leaves the input register, so back-to-back tokens see each other's effect without a bubble.
// Reset returns the block to the start of a message with both registers empty.
// A stalled result holds the input register, and token_stall rises only when it is full.
module irc_message_field_tagger_core
    import irc_mft_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    token_valid,
    output logic    token_stall,
    input  token_t  token,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    typedef enum logic [1:0] {
        PH_START,
        PH_PREFIX,
        PH_COMMAND,
        PH_PARAM
    } phase_t;

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_NUMERIC,
        CMD_NAME
    } cmd_kind_t;

    token_t    tok_reg;
    logic      tok_valid_reg, tok_valid_next;
    result_t   result_reg, result_next;
    logic      result_valid_reg;

    phase_t    phase_reg, phase_next;
    cmd_kind_t cmd_kind_reg, cmd_kind_next;
    logic [9:0] code_reg, code_next;
    logic [2:0] cmd_len_reg, cmd_len_next;
    logic [PARAMS_W-1:0] params_reg, params_next;
    logic      at_start_reg, at_start_next;
    logic      trailing_reg, trailing_next;
    logic      hold_reg, hold_next;

    logic       advance;
    logic       take;
    logic [2:0] kind;
    logic [3:0] digit;
    logic       eom;
    logic       clear;
    logic       do_cmd;
    logic [2:0] close_err;
    cmd_kind_t  first_kind;
    logic [13:0] acc_wide;

    assign advance     = !result_valid_reg || !result_stall;
    assign token_stall = tok_valid_reg && !advance;
    assign take        = token_valid && !token_stall;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        tok_valid_next = tok_valid_reg;
        if (take)
        begin
            tok_valid_next = 1'b1;
        end
        else if (advance)
        begin
            tok_valid_next = 1'b0;
        end
    end

    // Token cleanup: the spare kind counts as an other character, digits clamp at nine.
    assign kind  = (tok_reg.token_kind == TOK_SPARE) ? TOK_OTHER : tok_reg.token_kind;
    assign digit = (tok_reg.digit_value > DIGIT_MAX) ? DIGIT_MAX : tok_reg.digit_value;
    assign eom   = (kind == TOK_EOL) || (kind == TOK_EOI);

    assign close_err  = (cmd_kind_reg == CMD_NONE) ? ERR_NO_CMD :
                        ((cmd_kind_reg == CMD_NUMERIC) && (cmd_len_reg != CODE_DIGITS)) ?
                        ERR_CODE_LEN : ERR_NONE;
    assign first_kind = (kind == TOK_DIGIT) ? CMD_NUMERIC : CMD_NAME;
    assign acc_wide   = 14'(code_reg) * 14'd10 + 14'(digit);

    always_comb
    begin
        phase_next    = phase_reg;
        cmd_kind_next = cmd_kind_reg;
        code_next     = code_reg;
        cmd_len_next  = cmd_len_reg;
        params_next   = params_reg;
        at_start_next = at_start_reg;
        trailing_next = trailing_reg;
        hold_next     = hold_reg;
        clear         = 1'b0;
        do_cmd        = 1'b0;

        result_next.role        = ROLE_IGNORED;
        result_next.param_index = 4'd0;
        result_next.error_code  = ERR_NONE;
        result_next.last        = 1'b0;

        if (hold_reg)
        begin
            if (eom)
            begin
                result_next.role = ROLE_END;
                result_next.last = 1'b1;
                clear            = 1'b1;
            end
        end
        else
        begin
            case (phase_reg)
                PH_START:
                begin
                    if (kind == TOK_EOI)
                    begin
                        result_next.role = ROLE_IGNORED;
                    end
                    else if (kind == TOK_COLON)
                    begin
                        phase_next       = PH_PREFIX;
                        result_next.role = ROLE_DELIM;
                    end
                    else
                    begin
                        phase_next = PH_COMMAND;
                        do_cmd     = 1'b1;
                    end
                end
                PH_PREFIX:
                begin
                    if (eom)
                    begin
                        result_next.role = ROLE_END;
                        result_next.last = 1'b1;
                        clear            = 1'b1;
                    end
                    else if (kind == TOK_SPACE)
                    begin
                        phase_next       = PH_COMMAND;
                        result_next.role = ROLE_DELIM;
                    end
                    else
                    begin
                        result_next.role = ROLE_PREFIX;
                    end
                end
                PH_COMMAND:
                begin
                    do_cmd = 1'b1;
                end
                PH_PARAM:
                begin
                    if (eom)
                    begin
                        if (!at_start_reg)
                        begin
                            params_next = params_reg + PARAMS_W'(1);
                        end
                        result_next.role = ROLE_END;
                        result_next.last = 1'b1;
                        clear            = 1'b1;
                    end
                    else if ((kind == TOK_SPACE) && !trailing_reg)
                    begin
                        if (!at_start_reg)
                        begin
                            params_next   = params_reg + PARAMS_W'(1);
                            at_start_next = 1'b1;
                        end
                        result_next.role = ROLE_DELIM;
                    end
                    else if (at_start_reg && (params_reg >= PARAMS_W'(MAX_PARAMS)))
                    begin
                        result_next.role       = ROLE_IGNORED;
                        result_next.error_code = ERR_TOO_MANY;
                        hold_next              = 1'b1;
                    end
                    else if (at_start_reg && (kind == TOK_COLON) && !trailing_reg)
                    begin
                        at_start_next    = 1'b0;
                        trailing_next    = 1'b1;
                        result_next.role = ROLE_DELIM;
                    end
                    else
                    begin
                        at_start_next           = 1'b0;
                        result_next.role        = ROLE_PARAM;
                        result_next.param_index = params_reg[3:0];
                    end
                end
                default:
                begin
                    phase_next = PH_START;
                end
            endcase

            if (do_cmd)
            begin
                if ((kind == TOK_SPACE) || eom)
                begin
                    if (eom)
                    begin
                        result_next.role       = ROLE_END;
                        result_next.last       = 1'b1;
                        result_next.error_code = close_err;
                        clear                  = 1'b1;
                    end
                    else if (close_err != ERR_NONE)
                    begin
                        result_next.role       = ROLE_IGNORED;
                        result_next.error_code = close_err;
                        hold_next              = 1'b1;
                    end
                    else
                    begin
                        phase_next       = PH_PARAM;
                        at_start_next    = 1'b1;
                        result_next.role = ROLE_DELIM;
                    end
                end
                else
                begin
                    if (cmd_kind_reg == CMD_NONE)
                    begin
                        cmd_kind_next = first_kind;
                    end
                    if (((cmd_kind_next == CMD_NUMERIC) && (kind != TOK_DIGIT)) ||
                        ((cmd_kind_next == CMD_NAME) && (kind != TOK_ALPHA)))
                    begin
                        result_next.role       = ROLE_IGNORED;
                        result_next.error_code = ERR_BAD_CMD;
                        hold_next              = 1'b1;
                    end
                    else
                    begin
                        if ((cmd_kind_next == CMD_NUMERIC) && (cmd_len_reg < CODE_DIGITS))
                        begin
                            code_next = acc_wide[9:0];
                        end
                        if (cmd_len_reg < CMD_LEN_MAX)
                        begin
                            cmd_len_next = cmd_len_reg + 3'd1;
                        end
                        result_next.role = ROLE_COMMAND;
                    end
                end
            end
        end

        // The beat reports the state as it stands after this token, before a message end clears it.
        result_next.command_is_numeric = (cmd_kind_next == CMD_NUMERIC);
        result_next.command_code       = code_next;
        result_next.param_total        = params_next[3:0];

        if (clear)
        begin
            phase_next    = PH_START;
            cmd_kind_next = CMD_NONE;
            code_next     = 10'd0;
            cmd_len_next  = 3'd0;
            params_next   = '0;
            at_start_next = 1'b1;
            trailing_next = 1'b0;
            hold_next     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_valid_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
            phase_reg        <= PH_START;
            cmd_kind_reg     <= CMD_NONE;
            code_reg         <= 10'd0;
            cmd_len_reg      <= 3'd0;
            params_reg       <= '0;
            at_start_reg     <= 1'b1;
            trailing_reg     <= 1'b0;
            hold_reg         <= 1'b0;
        end
        else
        begin
            tok_valid_reg <= tok_valid_next;
            if (advance)
            begin
                result_valid_reg <= tok_valid_reg;
            end
            if (tok_valid_reg && advance)
            begin
                result_reg   <= result_next;
                phase_reg    <= phase_next;
                cmd_kind_reg <= cmd_kind_next;
                code_reg     <= code_next;
                cmd_len_reg  <= cmd_len_next;
                params_reg   <= params_next;
                at_start_reg <= at_start_next;
                trailing_reg <= trailing_next;
                hold_reg     <= hold_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            tok_reg <= token;
        end
    end

`ifndef SYNTHESIS
    a_hold_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (tok_valid_reg && advance && hold_reg) |=>
        ((result_reg.role == ROLE_IGNORED) || (result_reg.role == ROLE_END)))
        else $error("token after an error was not ignored");

    a_error_role: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && (result_reg.error_code != ERR_NONE)) |->
        ((result_reg.role == ROLE_IGNORED) || (result_reg.role == ROLE_END)))
        else $error("error reported on a tagged character");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (tok_valid_reg && advance && result_next.last) |=>
        ((phase_reg == PH_START) && (params_reg == '0) && !hold_reg))
        else $error("message end did not clear the message state");

    a_param_limit: assert property (@(posedge clk) disable iff (!rst_n)
        params_reg <= PARAMS_W'(MAX_PARAMS))
        else $error("parameter count passed its limit");

    a_trailing_open: assert property (@(posedge clk) disable iff (!rst_n)
        trailing_reg |-> !at_start_reg)
        else $error("trailing parameter marked as not started");
`endif

endmodule
